// ----- design/ogghp_pkg.sv -----
package ogghp_pkg;

    localparam logic [8:0] HDR_LEN     = 9'd27;
    localparam logic [8:0] POS_VERSION = 9'd4;
    localparam logic [8:0] POS_FLAGS   = 9'd5;
    localparam logic [8:0] POS_GRAN    = 9'd6;
    localparam logic [8:0] POS_SER     = 9'd14;
    localparam logic [8:0] POS_SEQ     = 9'd18;
    localparam logic [8:0] POS_CRC     = 9'd22;
    localparam logic [8:0] POS_SEGS    = 9'd26;

    localparam logic [7:0] FLAG_RESERVED_MASK = 8'hF8;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EOS         = 3'd1,
        ST_IO          = 3'd2,
        ST_MALFORMED   = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  header_flags;
        logic [63:0] granule_position;
        logic [31:0] serial_number;
        logic [31:0] page_sequence;
        logic [7:0]  segment_count;
        logic [15:0] page_size;
    } result_t;

    // "OggS" capture pattern
    function automatic logic [7:0] capture_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0: val = 8'h4F;
            2'd1: val = 8'h67;
            2'd2: val = 8'h67;
            2'd3: val = 8'h53;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ----- design/ogghp_in_reg.sv -----
module ogghp_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_stream_end,
    input  logic            take,
    output logic            item_valid,
    output ogghp_pkg::item_t item
);
    import ogghp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg.data_byte  <= s_data_byte;
            item_reg.stream_end <= s_stream_end;
        end
    end

endmodule

// ----- design/ogghp_core.sv -----
module ogghp_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  ogghp_pkg::item_t   item,
    output logic               res_valid,
    output ogghp_pkg::result_t res
);
    import ogghp_pkg::*;

    logic [8:0]  pos_reg, pos_next;
    logic        cap_reg, cap_next;
    logic [7:0]  ver_reg, ver_next;
    logic [7:0]  flag_reg, flag_next;
    logic [63:0] gran_reg, gran_next;
    logic [31:0] ser_reg, ser_next;
    logic [31:0] seq_reg, seq_next;
    logic [7:0]  seg_reg, seg_next;
    logic [15:0] lace_reg, lace_next;
    logic [7:0]  b;
    logic        clear;

    assign b = item.data_byte;

    always_comb begin
        pos_next  = pos_reg;
        cap_next  = cap_reg;
        ver_next  = ver_reg;
        flag_next = flag_reg;
        gran_next = gran_reg;
        ser_next  = ser_reg;
        seq_next  = seq_reg;
        seg_next  = seg_reg;
        lace_next = lace_reg;
        res_valid = 1'b0;
        res       = '0;
        clear     = 1'b0;

        if (item.stream_end) begin
            res_valid  = 1'b1;
            res.status = (pos_reg == '0) ? ST_EOS : ST_IO;
            clear      = 1'b1;
        end else if (pos_reg < HDR_LEN) begin
            // header bytes
            if (pos_reg < POS_VERSION) begin
                if (b != capture_byte(pos_reg[1:0])) begin
                    cap_next = 1'b0;
                end
            end else if (pos_reg == POS_VERSION) begin
                ver_next = b;
            end else if (pos_reg == POS_FLAGS) begin
                flag_next = b;
            end else if (pos_reg < POS_SER) begin
                gran_next = {b, gran_reg[63:8]};
            end else if (pos_reg < POS_SEQ) begin
                ser_next = {b, ser_reg[31:8]};
            end else if (pos_reg < POS_CRC) begin
                seq_next = {b, seq_reg[31:8]};
            end else if (pos_reg == POS_SEGS) begin
                seg_next = b;
            end
            pos_next = pos_reg + 9'd1;

            if (pos_reg == POS_SEGS) begin
                if (!cap_next) begin
                    res_valid  = 1'b1;
                    res.status = ST_MALFORMED;
                    clear      = 1'b1;
                end else if (ver_reg != 8'd0) begin
                    res_valid  = 1'b1;
                    res.status = ST_UNSUPPORTED;
                    clear      = 1'b1;
                end else if ((flag_reg & FLAG_RESERVED_MASK) != 8'd0) begin
                    res_valid  = 1'b1;
                    res.status = ST_MALFORMED;
                    clear      = 1'b1;
                end else if (b == 8'd0) begin
                    res_valid            = 1'b1;
                    res.status           = ST_OK;
                    res.header_flags     = flag_reg[2:0];
                    res.granule_position = gran_reg;
                    res.serial_number    = ser_reg;
                    res.page_sequence    = seq_reg;
                    res.segment_count    = 8'd0;
                    res.page_size        = {7'd0, HDR_LEN};
                    clear                = 1'b1;
                end
            end
        end else begin
            // lacing table
            lace_next = lace_reg + {8'd0, b};
            pos_next  = pos_reg + 9'd1;
            if (pos_next >= HDR_LEN + {1'b0, seg_reg}) begin
                res_valid            = 1'b1;
                res.status           = ST_OK;
                res.header_flags     = flag_reg[2:0];
                res.granule_position = gran_reg;
                res.serial_number    = ser_reg;
                res.page_sequence    = seq_reg;
                res.segment_count    = seg_reg;
                res.page_size        = {7'd0, HDR_LEN} + {8'd0, seg_reg} + lace_next;
                clear                = 1'b1;
            end
        end

        if (clear) begin
            pos_next  = '0;
            cap_next  = 1'b1;
            lace_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            cap_reg  <= 1'b1;
            lace_reg <= '0;
        end else if (step) begin
            pos_reg  <= pos_next;
            cap_reg  <= cap_next;
            lace_reg <= lace_next;
        end
        if (step) begin
            ver_reg  <= ver_next;
            flag_reg <= flag_next;
            gran_reg <= gran_next;
            ser_reg  <= ser_next;
            seq_reg  <= seq_next;
            seg_reg  <= seg_next;
        end
    end

endmodule

// ----- design/ogghp_out_reg.sv -----
module ogghp_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  ogghp_pkg::result_t res,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [2:0]         m_header_flags,
    output logic [63:0]        m_granule_position,
    output logic [31:0]        m_serial_number,
    output logic [31:0]        m_page_sequence,
    output logic [7:0]         m_segment_count,
    output logic [15:0]        m_page_size
);
    import ogghp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign m_valid            = valid_reg;
    assign m_status           = res_reg.status;
    assign m_header_flags     = res_reg.header_flags;
    assign m_granule_position = res_reg.granule_position;
    assign m_serial_number    = res_reg.serial_number;
    assign m_page_sequence    = res_reg.page_sequence;
    assign m_segment_count    = res_reg.segment_count;
    assign m_page_size        = res_reg.page_size;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ----- design/ogg_page_header_parser.sv -----
// the byte that ends the page is held in the input register; its result is held in the result register
// throughput: one byte per cycle; the input register and the result register decouple
// the two channels, and the parser steps whenever the result register is free or draining
// reset: aresetn synchronous, active low; clears both channel valids and the page position,
// so the block waits for the first header byte of a new page
module ogg_page_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_header_flags,
    output logic [63:0] m_granule_position,
    output logic [31:0] m_serial_number,
    output logic [31:0] m_page_sequence,
    output logic [7:0]  m_segment_count,
    output logic [15:0] m_page_size
);
    import ogghp_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    step;
    logic    res_valid;
    result_t res;

    assign step = item_valid && (!m_valid || m_ready);

    ogghp_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_stream_end (s_stream_end),
        .take         (step),
        .item_valid   (item_valid),
        .item         (item)
    );

    ogghp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ogghp_out_reg u_out_reg (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load               (step && res_valid),
        .res                (res),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_header_flags     (m_header_flags),
        .m_granule_position (m_granule_position),
        .m_serial_number    (m_serial_number),
        .m_page_sequence    (m_page_sequence),
        .m_segment_count    (m_segment_count),
        .m_page_size        (m_page_size)
    );

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ogghp_pkg::*;

    localparam int RANDOM_BYTES = 230;
    localparam logic [7:0] CAPTURE_PATTERN [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_stream_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [2:0]  m_header_flags;
    logic [63:0] m_granule_position;
    logic [31:0] m_serial_number;
    logic [31:0] m_page_sequence;
    logic [7:0]  m_segment_count;
    logic [15:0] m_page_size;

    ogg_page_header_parser uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_stream_end       (s_stream_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_header_flags     (m_header_flags),
        .m_granule_position (m_granule_position),
        .m_serial_number    (m_serial_number),
        .m_page_sequence    (m_page_sequence),
        .m_segment_count    (m_segment_count),
        .m_page_size        (m_page_size)
    );

    always #5 aclk = ~aclk;

    // parser state mirror
    logic [8:0]  pg_pos = '0;
    logic        pg_capture_ok = 1'b1;
    logic [7:0]  pg_version = '0;
    logic [7:0]  pg_flags = '0;
    logic [63:0] pg_granule = '0;
    logic [31:0] pg_serial = '0;
    logic [31:0] pg_sequence = '0;
    logic [7:0]  pg_segments = '0;
    logic [16:0] pg_lace_sum = '0;

    result_t     expected_pages [$];
    logic [7:0]  page_bytes [$];

    int failures = 0;
    int bytes_accepted = 0;
    int results_ok = 0;
    int results_err = 0;
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;
    int hold_cycles_requested = 0;
    int hold_token = 0;
    int hold_token_seen = 0;
    int sink_stall_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic clear_page_state();
        pg_pos = '0;
        pg_capture_ok = 1'b1;
        pg_version = '0;
        pg_flags = '0;
        pg_granule = '0;
        pg_serial = '0;
        pg_sequence = '0;
        pg_segments = '0;
        pg_lace_sum = '0;
    endtask

    task automatic advance_page_parse(input logic [7:0] b, input logic e);
        result_t page;
        status_t st;
        logic    done;
        done = 1'b0;
        st = ST_OK;
        if (e) begin
            done = 1'b1;
            st = (pg_pos == '0) ? ST_EOS : ST_IO;
        end else if (pg_pos < HDR_LEN) begin
            if (pg_pos < POS_VERSION) begin
                if (b != CAPTURE_PATTERN[pg_pos[1:0]]) pg_capture_ok = 1'b0;
            end else if (pg_pos == POS_VERSION) begin
                pg_version = b;
            end else if (pg_pos == POS_FLAGS) begin
                pg_flags = b;
            end else if (pg_pos < POS_SER) begin
                pg_granule = {b, pg_granule[63:8]};
            end else if (pg_pos < POS_SEQ) begin
                pg_serial = {b, pg_serial[31:8]};
            end else if (pg_pos < POS_CRC) begin
                pg_sequence = {b, pg_sequence[31:8]};
            end else if (pg_pos == POS_SEGS) begin
                pg_segments = b;
            end
            pg_pos = pg_pos + 9'd1;
            if (pg_pos == HDR_LEN) begin
                done = 1'b1;
                if (!pg_capture_ok) st = ST_MALFORMED;
                else if (pg_version != 8'h00) st = ST_UNSUPPORTED;
                else if ((pg_flags & FLAG_RESERVED_MASK) != 8'h00) st = ST_MALFORMED;
                else if (pg_segments == 8'h00) st = ST_OK;
                else done = 1'b0;
            end
        end else begin
            pg_lace_sum = pg_lace_sum + 17'(b);
            pg_pos = pg_pos + 9'd1;
            if (pg_pos >= HDR_LEN + 9'(pg_segments)) begin
                done = 1'b1;
                st = ST_OK;
            end
        end
        if (done) begin
            page = '0;
            page.status = st;
            if (st == ST_OK) begin
                page.header_flags = pg_flags[2:0];
                page.granule_position = pg_granule;
                page.serial_number = pg_serial;
                page.page_sequence = pg_sequence;
                page.segment_count = pg_segments;
                page.page_size = 16'(17'(HDR_LEN) + 17'(pg_segments) + pg_lace_sum);
            end
            expected_pages.push_back(page);
            clear_page_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_stream_end <= e;
        do @(posedge aclk); while (!s_ready);
        bytes_accepted++;
        advance_page_parse(b, e);
    endtask

    task automatic build_page(input logic [7:0] version, input logic [7:0] flags,
                              input logic [63:0] granule, input logic [31:0] serial,
                              input logic [31:0] page_seq, input logic [7:0] segs,
                              input int lace_lo, input int lace_hi);
        logic [31:0] crc;
        int k;
        crc = $urandom;
        page_bytes.delete();
        for (k = 0; k < 4; k++) page_bytes.push_back(CAPTURE_PATTERN[k]);
        page_bytes.push_back(version);
        page_bytes.push_back(flags);
        for (k = 0; k < 8; k++) page_bytes.push_back(granule[8*k +: 8]);
        for (k = 0; k < 4; k++) page_bytes.push_back(serial[8*k +: 8]);
        for (k = 0; k < 4; k++) page_bytes.push_back(page_seq[8*k +: 8]);
        for (k = 0; k < 4; k++) page_bytes.push_back(crc[8*k +: 8]);
        page_bytes.push_back(segs);
        for (k = 0; k < segs; k++) page_bytes.push_back(8'($urandom_range(lace_hi, lace_lo)));
    endtask

    task automatic build_valid_page(input logic [7:0] segs);
        build_page(8'h00, 8'($urandom_range(0, 7)), {$urandom, $urandom}, $urandom, $urandom,
                   segs, 0, 255);
    endtask

    // cut < 0 sends the whole page, otherwise byte cut becomes a stream end
    task automatic send_page_bytes(input int cut);
        int i;
        for (i = 0; i < page_bytes.size(); i++) begin
            if (i == cut) begin
                send_byte(8'($urandom), 1'b1);
                return;
            end
            send_byte(page_bytes[i], 1'b0);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endtask

    // result sink with random stalls and an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_token != hold_token_seen) begin
                hold_token_seen = hold_token;
                sink_stall_left = hold_cycles_requested;
            end else if (sink_stall_left == 0 && sink_idle_on && $urandom_range(0, 3) == 0) begin
                sink_stall_left = pick_gap();
            end
            if (sink_stall_left > 0) begin
                m_ready <= 1'b0;
                sink_stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pages.size() == 0) begin
                $error("unexpected result transaction, status %0d", m_status);
                failures++;
            end else begin
                want = expected_pages.pop_front();
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("header_flags", 64'(want.header_flags), 64'(m_header_flags));
                check_field("granule_position", want.granule_position, m_granule_position);
                check_field("serial_number", 64'(want.serial_number), 64'(m_serial_number));
                check_field("page_sequence", 64'(want.page_sequence), 64'(m_page_sequence));
                check_field("segment_count", 64'(want.segment_count), 64'(m_segment_count));
                check_field("page_size", 64'(want.page_size), 64'(m_page_size));
                if (want.status == ST_OK) results_ok++;
                else results_err++;
            end
        end
    end

    task automatic test_stream_end();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        build_valid_page(8'd3);
        send_page_bytes(1);
        build_valid_page(8'd3);
        send_page_bytes(26);
        build_valid_page(8'd1);
        send_page_bytes(27);
        build_valid_page(8'd3);
        send_page_bytes(28);
    endtask

    task automatic test_header_checks();
        int k;
        for (k = 0; k < 4; k++) begin
            build_valid_page(8'd0);
            page_bytes[k] = page_bytes[k] ^ 8'h20;
            send_page_bytes(-1);
        end
        build_page(8'h01, 8'h00, {$urandom, $urandom}, $urandom, $urandom, 8'd0, 0, 0);
        send_page_bytes(-1);
        build_page(8'hFF, 8'h07, {$urandom, $urandom}, $urandom, $urandom, 8'd0, 0, 0);
        send_page_bytes(-1);
        build_page(8'h00, 8'h08, {$urandom, $urandom}, $urandom, $urandom, 8'd0, 0, 0);
        send_page_bytes(-1);
        build_page(8'h00, 8'hF8, {$urandom, $urandom}, $urandom, $urandom, 8'd0, 0, 0);
        send_page_bytes(-1);
        // bad capture wins over version, version wins over flags
        build_page(8'h01, 8'hFF, {$urandom, $urandom}, $urandom, $urandom, 8'd0, 0, 0);
        page_bytes[0] = 8'h00;
        send_page_bytes(-1);
        build_page(8'h80, 8'hFF, {$urandom, $urandom}, $urandom, $urandom, 8'd0, 0, 0);
        send_page_bytes(-1);
    endtask

    task automatic test_field_extremes();
        build_page(8'h00, 8'h00, 64'h0, 32'h0, 32'h0, 8'd0, 0, 0);
        send_page_bytes(-1);
        build_page(8'h00, 8'h07, '1, '1, '1, 8'd0, 0, 0);
        send_page_bytes(-1);
        build_page(8'h00, 8'h05, 64'h0123_4567_89AB_CDEF, 32'hA5C3_5A3C, 32'h8000_0001,
                   8'd1, 255, 255);
        send_page_bytes(-1);
    endtask

    task automatic test_lacing_extremes();
        build_page(8'h00, 8'h02, {$urandom, $urandom}, $urandom, $urandom, 8'd1, 0, 0);
        send_page_bytes(-1);
        build_page(8'h00, 8'h04, {$urandom, $urandom}, $urandom, $urandom, 8'd255, 255, 255);
        send_page_bytes(-1);
        build_page(8'h00, 8'h01, {$urandom, $urandom}, $urandom, $urandom, 8'd255, 0, 0);
        send_page_bytes(-1);
    endtask

    task automatic test_output_backpressure();
        int k;
        src_idle_on = 1'b0;
        hold_cycles_requested = 300;
        hold_token++;
        for (k = 0; k < 5; k++) begin
            build_valid_page(8'd0);
            send_page_bytes(-1);
        end
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_pages();
        int stop_at;
        int r;
        int n;
        int k;
        logic [7:0] segs;
        stop_at = bytes_accepted + RANDOM_BYTES;
        while (bytes_accepted < stop_at) begin
            if ($urandom_range(0, 9) == 0) src_idle_on = !src_idle_on;
            if ($urandom_range(0, 9) == 0) sink_idle_on = !sink_idle_on;
            r = $urandom_range(0, 99);
            n = $urandom_range(0, 99);
            if (n < 80) segs = 8'($urandom_range(0, 6));
            else if (n < 95) segs = 8'($urandom_range(7, 40));
            else segs = 8'($urandom_range(41, 255));
            build_valid_page(segs);
            if (r < 70) begin
                send_page_bytes(-1);
            end else if (r < 80) begin
                k = $urandom_range(0, 26);
                page_bytes[k] = page_bytes[k] ^ 8'($urandom_range(1, 255));
                send_page_bytes(-1);
                send_byte(8'($urandom), 1'b1);
            end else if (r < 90) begin
                send_page_bytes($urandom_range(0, page_bytes.size() - 1));
            end else begin
                n = $urandom_range(1, 30);
                for (k = 0; k < n; k++)
                    send_byte(8'($urandom), $urandom_range(0, 9) == 0);
                send_byte(8'($urandom), 1'b1);
            end
        end
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_stream_end();
        test_header_checks();
        test_field_extremes();
        test_lacing_extremes();
        test_output_backpressure();
        test_random_pages();
        s_valid <= 1'b0;
        while (expected_pages.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("byte transactions: %0d, page results checked: %0d ok and %0d with error status",
                 bytes_accepted, results_ok, results_err);
        $display("covered stream ends, header checks, field and lacing extremes, output stall");
        if (failures == 0) begin
            $display("** ogg_page_header_parser: PASSED **");
        end else begin
            $display("** ogg_page_header_parser: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout waiting for transactions");
        $display("** ogg_page_header_parser: FAILED **");
        $finish;
    end

endmodule
